/* src/psl_pkg.sv */
// ----------------------------------------------------------------------------
// psl_pkg: shared types and constants for the positional sorted list store
// Field widths, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int FUNC_W      = 3;
  localparam int POS_W       = 8;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;

  localparam logic [POS_W-1:0] POS_FAIL = 8'hFF;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT_AT     = 3'd0,
    FN_INSERT_SORTED = 3'd1,
    FN_ERASE         = 3'd2,
    FN_REMOVE_ALL    = 3'd3,
    FN_GET           = 3'd4,
    FN_SET           = 3'd5,
    FN_FIND          = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_RANGE     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  // Control word broadcast to every cell, decoded per cell by the top level.
  typedef struct packed {
    logic capture;     // register compare flag and read tap this cycle
    logic cmp_le;      // flag is value <= element, else value == element
    logic valid;       // cell index is below the element count
    logic tap_sel;     // cell index equals the requested position
    logic load_new;    // take the request value
    logic from_left;   // take the left neighbor (gap opens)
    logic from_right;  // take the right neighbor (gap closes)
  } cell_ctl_t;

endpackage

/* src/psl_if.sv */
// ----------------------------------------------------------------------------
// psl_req_if / psl_rsp_if: request and response channels
// Valid/ready handshake; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface psl_req_if import psl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [POS_W-1:0]   pos;
  logic [VALUE_W-1:0] new_value;

  modport source (output valid, output func, output pos, output new_value, input ready);
  modport sink   (input valid, input func, input pos, input new_value, output ready);
endinterface

interface psl_rsp_if import psl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [POS_W-1:0]       position;
  logic [VALUE_W-1:0]     read_value;
  logic [COUNT_OUT_W-1:0] removed;
  logic [COUNT_OUT_W-1:0] length;

  modport source (output valid, output status, output position, output read_value,
                  output removed, output length, input ready);
  modport sink   (input valid, input status, input position, input read_value,
                  input removed, input length, output ready);
endinterface

/* src/positional_sorted_list_store.sv */
// ----------------------------------------------------------------------------
// positional_sorted_list_store: bounded ordered list on a shifting cell row
//
//   channel | dir | payload                                        | beat
//   req_i   | in  | func, pos, new_value                           | valid & ready
//   rsp_o   | out | status, position, read_value, removed, length  | valid & ready
//
// insert_at, erase, set and unused codes go straight to the shift step.
// get, find and insert_sorted compare in the cells, then pass two scan
// tree stages, then the shift. remove_all makes one pass of compare, scan
// and close-gap per match, then a last pass that finds none and responds.
// Reset clears element count, state and response; cell contents undefined.
// The shift step waits while a response beat is held and not taken.
// ----------------------------------------------------------------------------
module positional_sorted_list_store import psl_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  psl_req_if.sink   req_i,
  psl_rsp_if.source rsp_o
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > POS_W) ? CW : POS_W;
  localparam int XW  = (ITEM_WIDTH > VALUE_W) ? ITEM_WIDTH : VALUE_W;
  localparam int LXW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  typedef enum logic [2:0] {S_IDLE, S_CMP, S_GRP, S_SEL, S_EXEC} state_e;

  state_e                 state_q;
  func_e                  func_q;
  logic [POS_W-1:0]       pos_q;
  logic [ITEM_WIDTH-1:0]  val_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          removed_q;

  logic                   rsp_valid_q;
  status_e                status_q;
  logic [POS_W-1:0]       position_q;
  logic [VALUE_W-1:0]     read_value_q;
  logic [COUNT_OUT_W-1:0] removed_out_q;
  logic [COUNT_OUT_W-1:0] length_q;

  logic [ITEM_WIDTH-1:0]  elem [CAPACITY];
  logic [ITEM_WIDTH-1:0]  tap  [CAPACITY];
  logic [CAPACITY-1:0]    hit_vec;

  logic                   scan_hit;
  logic [CW-1:0]          scan_idx;
  logic [ITEM_WIDTH-1:0]  scan_rd;

  logic [XW-1:0]          val_wide;
  logic [XW-1:0]          rd_wide;
  logic [PW-1:0]          pos_ext;
  logic [PW-1:0]          count_ext;
  logic [PW-1:0]          tgt_ext;
  logic [LXW-1:0]         len_ext;
  logic [LXW-1:0]         rem_ext;

  logic                   needs_scan;
  logic                   exec_go;
  logic [CW-1:0]          tgt;
  logic                   do_ins, do_del, do_wr, respond, fail, pos_zero, rd_sel, rem_sel;
  status_e                sts;
  logic                   full;
  logic [CW-1:0]          cnt_next;

  assign val_wide  = XW'(req_i.new_value);
  assign rd_wide   = XW'(scan_rd);
  assign pos_ext   = PW'(pos_q);
  assign count_ext = PW'(count_q);
  assign tgt_ext   = PW'(tgt);
  assign len_ext   = LXW'(cnt_next);
  assign rem_ext   = LXW'(removed_q);
  assign full      = (count_q == CW'(CAPACITY));

  always_comb begin
    case (func_e'(req_i.func)) inside
      FN_INSERT_SORTED, FN_REMOVE_ALL, FN_GET, FN_FIND: needs_scan = 1'b1;
      default:                                           needs_scan = 1'b0;
    endcase
  end

  assign exec_go = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  // operation decode for the shift step
  always_comb begin
    tgt      = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_wr    = 1'b0;
    respond  = 1'b1;
    sts      = STS_OK;
    fail     = 1'b0;
    pos_zero = 1'b0;
    rd_sel   = 1'b0;
    rem_sel  = 1'b0;
    unique case (func_q)
      FN_INSERT_AT: begin
        tgt = pos_ext[CW-1:0];
        if (pos_ext > count_ext) begin
          sts  = STS_RANGE;
          fail = 1'b1;
        end else if (full) begin
          sts  = STS_FULL;
          fail = 1'b1;
        end else begin
          do_ins = 1'b1;
        end
      end
      FN_INSERT_SORTED: begin
        // no element >= value: append at the old length
        tgt = scan_hit ? scan_idx : count_q;
        if (full) begin
          sts  = STS_FULL;
          fail = 1'b1;
        end else begin
          do_ins = 1'b1;
        end
      end
      FN_ERASE: begin
        tgt = pos_ext[CW-1:0];
        if (pos_ext >= count_ext) begin
          sts  = STS_RANGE;
          fail = 1'b1;
        end else begin
          do_del = 1'b1;
        end
      end
      FN_REMOVE_ALL: begin
        tgt      = scan_idx;
        pos_zero = 1'b1;
        rem_sel  = 1'b1;
        if (scan_hit) begin
          do_del  = 1'b1;
          respond = 1'b0;
        end
      end
      FN_GET: begin
        tgt = pos_ext[CW-1:0];
        if (pos_ext >= count_ext) begin
          sts  = STS_RANGE;
          fail = 1'b1;
        end else begin
          rd_sel = 1'b1;
        end
      end
      FN_SET: begin
        tgt = pos_ext[CW-1:0];
        if (pos_ext >= count_ext) begin
          sts  = STS_RANGE;
          fail = 1'b1;
        end else begin
          do_wr = 1'b1;
        end
      end
      FN_FIND: begin
        tgt = scan_idx;
        if (!scan_hit) begin
          sts  = STS_NOT_FOUND;
          fail = 1'b1;
        end
      end
      default: begin
        pos_zero = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (do_ins) begin
      cnt_next = count_q + CW'(1);
    end else if (do_del) begin
      cnt_next = count_q - CW'(1);
    end else begin
      cnt_next = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      func_q        <= FN_INSERT_AT;
      pos_q         <= '0;
      val_q         <= '0;
      count_q       <= '0;
      removed_q     <= '0;
      rsp_valid_q   <= 1'b0;
      status_q      <= STS_OK;
      position_q    <= '0;
      read_value_q  <= '0;
      removed_out_q <= '0;
      length_q      <= '0;
    end else begin
      // a new beat loaded below takes the place of the one leaving
      if (rsp_valid_q && rsp_o.ready && !(exec_go && respond)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            func_q    <= func_e'(req_i.func);
            pos_q     <= req_i.pos;
            val_q     <= val_wide[ITEM_WIDTH-1:0];
            removed_q <= '0;
            state_q   <= needs_scan ? S_CMP : S_EXEC;
          end
        end
        S_CMP:  state_q <= S_GRP;
        S_GRP:  state_q <= S_SEL;
        S_SEL:  state_q <= S_EXEC;
        S_EXEC: begin
          if (exec_go) begin
            count_q <= cnt_next;
            if (respond) begin
              rsp_valid_q   <= 1'b1;
              status_q      <= sts;
              position_q    <= fail ? POS_FAIL : (pos_zero ? '0 : tgt_ext[POS_W-1:0]);
              read_value_q  <= rd_sel ? rd_wide[VALUE_W-1:0] : '0;
              removed_out_q <= rem_sel ? rem_ext[COUNT_OUT_W-1:0] : '0;
              length_q      <= len_ext[COUNT_OUT_W-1:0];
              state_q       <= S_IDLE;
            end else begin
              // one match closed; rescan for the next
              removed_q <= removed_q + CW'(1);
              state_q   <= S_CMP;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.position   = position_q;
  assign rsp_o.read_value = read_value_q;
  assign rsp_o.removed    = removed_out_q;
  assign rsp_o.length     = length_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t             ctl;
    logic [ITEM_WIDTH-1:0] nb_left;
    logic [ITEM_WIDTH-1:0] nb_right;
    logic                  at_tgt;
    logic                  above_tgt;

    assign at_tgt    = (CW'(i) == tgt);
    assign above_tgt = (CW'(i) > tgt);

    always_comb begin
      ctl.capture    = (state_q == S_CMP);
      ctl.cmp_le     = (func_q == FN_INSERT_SORTED);
      ctl.valid      = (CW'(i) < count_q);
      ctl.tap_sel    = (pos_ext == PW'(i));
      ctl.load_new   = exec_go && (do_ins || do_wr) && at_tgt;
      ctl.from_left  = exec_go && do_ins && above_tgt;
      ctl.from_right = exec_go && do_del && (at_tgt || above_tgt);
    end

    if (i == 0) begin : g_first
      assign nb_left = val_q;
    end else begin : g_mid_l
      assign nb_left = elem[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign nb_right = '0;
    end else begin : g_mid_r
      assign nb_right = elem[i+1];
    end

    psl_cell #(.W(ITEM_WIDTH)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .new_i   (val_q),
      .left_i  (nb_left),
      .right_i (nb_right),
      .elem_o  (elem[i]),
      .hit_o   (hit_vec[i]),
      .tap_o   (tap[i])
    );
  end

  psl_scan #(.N(CAPACITY), .W(ITEM_WIDTH), .CW(CW)) u_scan (
    .clk_i    (clk_i),
    .grp_en_i (state_q == S_GRP),
    .sel_en_i (state_q == S_SEL),
    .hit_i    (hit_vec),
    .tap_i    (tap),
    .hit_o    (scan_hit),
    .idx_o    (scan_idx),
    .rd_o     (scan_rd)
  );

endmodule

/* src/psl_cell.sv */
// ----------------------------------------------------------------------------
// psl_cell: one storage cell of the list row
// Holds one element, shifts from either neighbor, and registers a compare
// flag and a masked read tap for the scan tree.
// ----------------------------------------------------------------------------
module psl_cell import psl_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  cell_ctl_t    ctl_i,
  input  logic [W-1:0] new_i,
  input  logic [W-1:0] left_i,
  input  logic [W-1:0] right_i,
  output logic [W-1:0] elem_o,
  output logic         hit_o,
  output logic [W-1:0] tap_o
);

  logic [W-1:0] elem_q, elem_d;
  logic         hit_q;
  logic [W-1:0] tap_q;
  logic         match;

  always_comb begin
    if (ctl_i.load_new) begin
      elem_d = new_i;
    end else if (ctl_i.from_left) begin
      elem_d = left_i;
    end else if (ctl_i.from_right) begin
      elem_d = right_i;
    end else begin
      elem_d = elem_q;
    end
  end

  assign match = ctl_i.cmp_le ? (new_i <= elem_q) : (new_i == elem_q);

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    if (ctl_i.capture) begin
      hit_q <= ctl_i.valid && match;
      tap_q <= (ctl_i.valid && ctl_i.tap_sel) ? elem_q : '0;
    end
  end

  assign elem_o = elem_q;
  assign hit_o  = hit_q;
  assign tap_o  = tap_q;

endmodule

/* src/psl_scan.sv */
// ----------------------------------------------------------------------------
// psl_scan: registered two-level scan over the cell row
// First level reduces groups of eight cells (first hit, OR of taps); second
// level picks the first group with a hit and ORs the group taps.
// ----------------------------------------------------------------------------
module psl_scan import psl_pkg::*; #(
  parameter int N  = 64,
  parameter int W  = 32,
  parameter int CW = 7
) (
  input  logic          clk_i,
  input  logic          grp_en_i,
  input  logic          sel_en_i,
  input  logic [N-1:0]  hit_i,
  input  logic [W-1:0]  tap_i [N],
  output logic          hit_o,
  output logic [CW-1:0] idx_o,
  output logic [W-1:0]  rd_o
);

  localparam int G  = 8;
  localparam int NG = (N + G - 1) / G;
  localparam int LW = $clog2(G);

  logic          grp_any_q [NG];
  logic [LW-1:0] grp_idx_q [NG];
  logic [W-1:0]  grp_rd_q  [NG];

  logic          grp_any_d [NG];
  logic [LW-1:0] grp_idx_d [NG];
  logic [W-1:0]  grp_rd_d  [NG];

  logic          hit_q, hit_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [W-1:0]  rd_q, rd_d;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      grp_rd_d[g]  = '0;
      // walk down so the lowest hit wins
      for (int k = G - 1; k >= 0; k--) begin
        if (g * G + k < N) begin
          if (hit_i[g * G + k]) begin
            grp_any_d[g] = 1'b1;
            grp_idx_d[g] = LW'(k);
          end
          grp_rd_d[g] = grp_rd_d[g] | tap_i[g * G + k];
        end
      end
    end
  end

  always_comb begin
    hit_d = 1'b0;
    idx_d = '0;
    rd_d  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        hit_d = 1'b1;
        idx_d = CW'(g * G) | CW'(grp_idx_q[g]);
      end
      rd_d = rd_d | grp_rd_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_en_i) begin
      for (int g = 0; g < NG; g++) begin
        grp_any_q[g] <= grp_any_d[g];
        grp_idx_q[g] <= grp_idx_d[g];
        grp_rd_q[g]  <= grp_rd_d[g];
      end
    end
    if (sel_en_i) begin
      hit_q <= hit_d;
      idx_q <= idx_d;
      rd_q  <= rd_d;
    end
  end

  assign hit_o = hit_q;
  assign idx_o = idx_q;
  assign rd_o  = rd_q;

endmodule

/* src/psl_checker.sv */
// ----------------------------------------------------------------------------
// psl_checker: port-level checks for the positional sorted list store
// Watches the response channel for consistency of its fields over time.
// ----------------------------------------------------------------------------
module psl_checker import psl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic [STATUS_W-1:0]    status_i,
  input logic [POS_W-1:0]       position_i,
  input logic [VALUE_W-1:0]     read_value_i,
  input logic [COUNT_OUT_W-1:0] removed_i,
  input logic [COUNT_OUT_W-1:0] length_i
);

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (int'(length_i) <= CAPACITY))
    else $error("length beyond capacity");

  a_fail_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (status_i != STS_OK)) |-> (position_i == POS_FAIL))
    else $error("failed result without position -1");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (read_value_i != '0)) |-> ((status_i == STS_OK) && (removed_i == '0)))
    else $error("read value on a failed or remove result");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable({status_i, position_i, read_value_i, removed_i, length_i})))
    else $error("stalled response beat changed");

endmodule

bind positional_sorted_list_store psl_checker #(.CAPACITY(CAPACITY)) u_psl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .position_i   (rsp_o.position),
  .read_value_i (rsp_o.read_value),
  .removed_i    (rsp_o.removed),
  .length_i     (rsp_o.length)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_sorted_list_store
// Drives request beats (directed corner cases, then random phases that fill,
// drain and search the list) and checks every response beat against an
// in-bench shadow of the list, with random request gaps and response stalls.
// ----------------------------------------------------------------------------
module testbench;
  import psl_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 424;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_REPORTS  = 50;

  // Selector code the block does not define; must be a no-op.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  typedef enum int {PH_MIXED, PH_FILL, PH_DRAIN, PH_SORTED} phase_e;

  typedef struct {
    status_e                status;
    logic [POS_W-1:0]       position;
    logic [VALUE_W-1:0]     read_value;
    logic [COUNT_OUT_W-1:0] removed;
    logic [COUNT_OUT_W-1:0] length;
  } rsp_t;

  class list_scoreboard;
    logic [VALUE_W-1:0] cells [CAPACITY];
    int unsigned        len;
    rsp_t               expected_q [$];
    int                 errors;

    function new();
      len    = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endfunction

    function void open_gap(int at, logic [VALUE_W-1:0] v);
      for (int i = len; i > at; i--) cells[i] = cells[i-1];
      cells[at] = v;
      len++;
    endfunction

    // Shadow update on an accepted request beat; queues the expected response.
    function void note_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                               logic [VALUE_W-1:0] v);
      rsp_t r;
      bit   fail;
      int   i;
      int   w;
      r.status     = STS_OK;
      r.position   = '0;
      r.read_value = '0;
      r.removed    = '0;
      fail         = 1'b0;
      case (f)
        FN_INSERT_AT: begin
          if (p > len) begin
            r.status = STS_RANGE;
            fail     = 1'b1;
          end else if (len >= CAPACITY) begin
            r.status = STS_FULL;
            fail     = 1'b1;
          end else begin
            open_gap(int'(p), v);
            r.position = p;
          end
        end
        FN_INSERT_SORTED: begin
          if (len >= CAPACITY) begin
            r.status = STS_FULL;
            fail     = 1'b1;
          end else begin
            i = 0;
            while (i < len && v > cells[i]) i++;
            open_gap(i, v);
            r.position = POS_W'(i);
          end
        end
        FN_ERASE: begin
          if (p >= len) begin
            r.status = STS_RANGE;
            fail     = 1'b1;
          end else begin
            for (i = int'(p); i + 1 < len; i++) cells[i] = cells[i+1];
            len--;
            r.position = p;
          end
        end
        FN_REMOVE_ALL: begin
          w = 0;
          for (i = 0; i < len; i++) begin
            if (cells[i] == v) r.removed++;
            else begin
              cells[w] = cells[i];
              w++;
            end
          end
          len = w;
        end
        FN_GET: begin
          if (p >= len) begin
            r.status = STS_RANGE;
            fail     = 1'b1;
          end else begin
            r.read_value = cells[p];
            r.position   = p;
          end
        end
        FN_SET: begin
          if (p >= len) begin
            r.status = STS_RANGE;
            fail     = 1'b1;
          end else begin
            cells[p]   = v;
            r.position = p;
          end
        end
        FN_FIND: begin
          i = 0;
          while (i < len && cells[i] != v) i++;
          if (i < len) r.position = POS_W'(i);
          else begin
            r.status = STS_NOT_FOUND;
            fail     = 1'b1;
          end
        end
        default: ;
      endcase
      if (fail) r.position = POS_FAIL;
      r.length = COUNT_OUT_W'(len);
      expected_q.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report("response beat with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.position !== want.position)
        report($sformatf("position got %h want %h", got.position, want.position));
      if (got.read_value !== want.read_value)
        report($sformatf("read_value got %h want %h", got.read_value, want.read_value));
      if (got.removed !== want.removed)
        report($sformatf("removed got %0d want %0d", got.removed, want.removed));
      if (got.length !== want.length)
        report($sformatf("length got %0d want %0d", got.length, want.length));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;

  list_scoreboard sb = new();

  psl_req_if req_if ();
  psl_rsp_if rsp_if ();

  positional_sorted_list_store #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(VALUE_W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    rsp_t got;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status     = status_e'(rsp_if.status);
        got.position   = rsp_if.position;
        got.read_value = rsp_if.read_value;
        got.removed    = rsp_if.removed;
        got.length     = rsp_if.length;
        sb.check_response(got);
      end
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.func, req_if.pos, req_if.new_value);
    end
  end

  // Mostly zero, often short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : rsp_side
    int stall;
    bit calm_rx;
    rsp_if.ready = 1'b0;
    stall        = 0;
    calm_rx      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(299) == 0) calm_rx = !calm_rx;
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        stall--;
      end else begin
        rsp_if.ready = 1'b1;
        if (!calm_rx && $urandom_range(3) == 0) stall = gap_len();
      end
    end
  end

  // Called just after a falling edge; valid stays high until the beat moves.
  task automatic drive_beat(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                            logic [VALUE_W-1:0] v);
    req_if.valid     = 1'b1;
    req_if.func      = f;
    req_if.pos       = p;
    req_if.new_value = v;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                      logic [VALUE_W-1:0] v);
    @(negedge clk_i);
    drive_beat(f, p, v);
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void pick_item(phase_e ph, output logic [FUNC_W-1:0] f,
                                    output logic [POS_W-1:0] p,
                                    output logic [VALUE_W-1:0] v);
    int r;
    int n;
    n = sb.len;
    r = $urandom_range(99);
    case (ph)
      PH_FILL:
        f = (r < 45) ? FN_INSERT_AT : (r < 90) ? FN_INSERT_SORTED :
            (r < 95) ? FN_GET : FN_FIND;
      PH_DRAIN:
        f = (r < 40) ? FN_ERASE : (r < 60) ? FN_REMOVE_ALL : (r < 75) ? FN_GET :
            (r < 90) ? FN_FIND : (r < 99) ? FN_SET : FN_UNUSED;
      PH_SORTED:
        f = (r < 40) ? FN_INSERT_SORTED : (r < 55) ? FN_FIND :
            (r < 65) ? FN_REMOVE_ALL : (r < 80) ? FN_GET :
            (r < 90) ? FN_ERASE : FN_SET;
      default:
        f = (r < 15) ? FN_INSERT_AT : (r < 30) ? FN_INSERT_SORTED :
            (r < 42) ? FN_ERASE : (r < 50) ? FN_REMOVE_ALL : (r < 65) ? FN_GET :
            (r < 77) ? FN_SET : (r < 99) ? FN_FIND : FN_UNUSED;
    endcase

    if ($urandom_range(99) < 12) p = POS_W'($urandom_range(255));
    else if (f == FN_INSERT_AT) p = POS_W'($urandom_range(n));
    else if (n > 0) p = POS_W'($urandom_range(n - 1));
    else p = POS_W'($urandom_range(3));

    // Small pool and existing values make duplicates, hits and ties common.
    r = $urandom_range(99);
    if (r < 35) v = $urandom_range(7);
    else if (r < 55 && n > 0) v = sb.cells[$urandom_range(n - 1)];
    else if (r < 65) v = $urandom_range(1) ? '1 : '0;
    else v = $urandom;
  endfunction

  initial begin : stimulus
    logic [FUNC_W-1:0]  f;
    logic [POS_W-1:0]   p;
    logic [VALUE_W-1:0] v;
    phase_e ph;
    int     total;
    int     phase_no;
    int     quota;
    bit     calm;

    req_if.valid     = 1'b0;
    req_if.func      = '0;
    req_if.pos       = '0;
    req_if.new_value = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty store: every access fails, remove_all finds nothing.
    send(FN_GET,           8'd0,   32'h0);
    send(FN_ERASE,         8'd0,   32'h0);
    send(FN_SET,           8'd0,   32'h1);
    send(FN_FIND,          8'd0,   32'h0);
    send(FN_REMOVE_ALL,    8'd0,   32'h5);
    send(FN_INSERT_AT,     8'd1,   32'h7);
    // Build a short list, including a sorted insert past the last element.
    send(FN_INSERT_AT,     8'd0,   32'h0000_0010);
    send(FN_INSERT_SORTED, 8'd0,   32'h0000_0020);
    send(FN_INSERT_SORTED, 8'd0,   32'h0000_0000);
    send(FN_INSERT_SORTED, 8'd0,   32'h0000_0010);
    send(FN_INSERT_AT,     8'd4,   32'hFFFF_FFFF);
    send(FN_INSERT_AT,     8'd6,   32'h1);
    send(FN_INSERT_AT,     8'd255, 32'h1);
    send(FN_GET,           8'd4,   32'h0);
    send(FN_GET,           8'd5,   32'h0);
    send(FN_SET,           8'd2,   32'hA5A5_5A5A);
    send(FN_SET,           8'd255, 32'h1);
    send(FN_FIND,          8'd0,   32'h0000_0010);
    send(FN_FIND,          8'd0,   32'h1234_5678);
    send(FN_REMOVE_ALL,    8'd0,   32'h0000_0010);
    send(FN_INSERT_AT,     8'd1,   32'h0);
    send(FN_REMOVE_ALL,    8'd0,   32'h0);
    send(FN_ERASE,         8'd0,   32'h0);
    send(FN_ERASE,         8'd255, 32'h0);
    send(FN_UNUSED,        8'd3,   32'hFFFF_FFFF);
    send(FN_GET,           8'd0,   32'h0);

    total    = 0;
    phase_no = 0;
    while (total < RANDOM_ITEMS) begin
      // Second phase runs the store into full, third works it back down.
      ph    = (phase_no == 1) ? PH_FILL : (phase_no == 2) ? PH_DRAIN :
              phase_e'($urandom_range(3));
      calm  = ($urandom_range(3) == 0);
      quota = (ph == PH_FILL) ? 2 * CAPACITY : $urandom_range(20, 60);
      for (int k = 0; k < quota && total < RANDOM_ITEMS; k++) begin
        if (!calm) idle(gap_len());
        @(negedge clk_i);
        pick_item(ph, f, p, v);
        drive_beat(f, p, v);
        total++;
      end
      if (phase_no == 0 || $urandom_range(3) == 0) wait_drained();
      phase_no++;
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/psl_pkg.sv
src/psl_if.sv
src/psl_cell.sv
src/psl_scan.sv
src/positional_sorted_list_store.sv
src/psl_checker.sv
bench/testbench.sv
